[rtl/core/fpa_pkg.sv]
package fpa_pkg;

  // Widths of the fixed fields and of the configuration index.
  localparam int unsigned MAX_PARTS       = 4;
  localparam int unsigned OP_BITS         = 3;
  localparam int unsigned STATUS_BITS     = 2;
  localparam int unsigned PART_INDEX_BITS = 2;
  localparam int unsigned CFG_INDEX_BITS  = 3;

  // Bit 0 of a configuration index selects the size register of a partition.
  localparam logic CFG_SEL_BASE = 1'b0;
  localparam logic CFG_SEL_SIZE = 1'b1;

  typedef enum logic [OP_BITS-1:0] {
    OP_ASSIGN    = 3'd0,
    OP_FREE      = 3'd1,
    OP_TRANSLATE = 3'd2,
    OP_READ      = 3'd3,
    OP_WRITE     = 3'd4
  } fpa_op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BOUNDS   = 2'd3
  } fpa_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2
  } fpa_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } fpa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic match;
    logic last;
    logic out_free;
  } fpa_stat_t;

endpackage

[rtl/core/fpa_req_if.sv]
interface fpa_req_if #(
  parameter int unsigned ADDRESS_BITS = 20,
  parameter int unsigned ID_BITS      = 16
);
  logic                              valid;
  logic                              ready;
  logic [fpa_pkg::OP_BITS-1:0]       opcode;
  logic [ID_BITS-1:0]                prog_id;
  logic [ADDRESS_BITS-1:0]           request_size;
  logic [ADDRESS_BITS-1:0]           virt_addr;

  modport source (
    output valid, opcode, prog_id, request_size, virt_addr,
    input  ready
  );
  modport sink (
    input  valid, opcode, prog_id, request_size, virt_addr,
    output ready
  );
endinterface

[rtl/core/fpa_rsp_if.sv]
interface fpa_rsp_if #(
  parameter int unsigned ADDRESS_BITS = 20
);
  logic                                   valid;
  logic                                   ready;
  logic [fpa_pkg::STATUS_BITS-1:0]        status;
  logic [fpa_pkg::PART_INDEX_BITS-1:0]    part_index;
  logic [ADDRESS_BITS:0]                  abs_address;
  logic                                   all_free;

  modport source (
    output valid, status, part_index, abs_address, all_free,
    input  ready
  );
  modport sink (
    input  valid, status, part_index, abs_address, all_free,
    output ready
  );
endinterface

[rtl/core/fpa_ctrl.sv]
module fpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  fpa_pkg::fpa_stat_t stat_i,
  output fpa_pkg::fpa_cmd_t  cmd_o
);

  fpa_pkg::fpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      fpa_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fpa_pkg::S_SCAN;
        end
      end
      fpa_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        // The scan stops at the first matching partition.
        if (stat_i.match || stat_i.last) begin
          state_d = fpa_pkg::S_EXEC;
        end
      end
      fpa_pkg::S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = fpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/fpa_dp.sv]
module fpa_dp #(
  parameter int unsigned PARTS        = 4,
  parameter int unsigned ADDRESS_BITS = 20,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpa_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [ADDRESS_BITS-1:0]             cfg_data_i,
  input  logic [fpa_pkg::OP_BITS-1:0]         req_opcode_i,
  input  logic [ID_BITS-1:0]                  req_id_i,
  input  logic [ADDRESS_BITS-1:0]             req_size_i,
  input  logic [ADDRESS_BITS-1:0]             req_va_i,
  input  fpa_pkg::fpa_cmd_t                   cmd_i,
  output fpa_pkg::fpa_stat_t                  stat_o,
  fpa_rsp_if.source                           rsp_o
);

  localparam int unsigned IDX_BITS = (PARTS > 1) ? $clog2(PARTS) : 1;
  localparam int unsigned NSLOT    = 2 ** IDX_BITS;
  localparam int unsigned END_BITS = ADDRESS_BITS + 3;

  logic [ADDRESS_BITS-1:0] base_q [NSLOT];
  logic [ADDRESS_BITS-1:0] size_q [NSLOT];
  logic [ID_BITS-1:0]      owner_q [NSLOT];
  logic [ID_BITS-1:0]      owner_d [NSLOT];
  logic [NSLOT-1:0]        occ_q, occ_d;

  fpa_pkg::fpa_op_e        op_q, op_in;
  logic [ID_BITS-1:0]      id_q;
  logic [ADDRESS_BITS-1:0] req_q;
  logic [ADDRESS_BITS-1:0] va_q;
  logic [END_BITS-1:0]     end_q;
  logic [IDX_BITS-1:0]     cnt_q;
  logic                    hit_q;
  logic [IDX_BITS-1:0]     hit_idx_q;

  logic                    rsp_valid_q;
  fpa_pkg::fpa_status_e    status_q, status_d;
  logic [fpa_pkg::PART_INDEX_BITS-1:0] pidx_q, pidx_d;
  logic [ADDRESS_BITS:0]   abs_q, abs_d;
  logic                    all_free_q;

  logic                    fit, own, match;
  logic [ADDRESS_BITS:0]   abs_sum;

  assign op_in = fpa_pkg::fpa_op_e'(req_opcode_i);

  // Configuration registers; partitions beyond PARTS are not stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NSLOT; p++) begin
        base_q[p] <= '0;
        size_q[p] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int p = 0; p < PARTS; p++) begin
        if (cfg_index_i[fpa_pkg::CFG_INDEX_BITS-1:1] ==
            (fpa_pkg::CFG_INDEX_BITS-1)'(p)) begin
          if (cfg_index_i[0] == fpa_pkg::CFG_SEL_SIZE) begin
            size_q[p] <= cfg_data_i;
          end else begin
            base_q[p] <= cfg_data_i;
          end
        end
      end
    end
  end

  // Request capture. The end of the access is formed here so that the
  // bound check later needs a single compare.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_in;
      id_q  <= req_id_i;
      req_q <= req_size_i;
      va_q  <= req_va_i;
      if (op_in == fpa_pkg::OP_TRANSLATE) begin
        end_q <= END_BITS'(req_va_i);
      end else begin
        end_q <= END_BITS'(req_va_i) + (END_BITS'(req_size_i) << 2);
      end
    end
  end

  // One partition is examined per scan cycle.
  assign fit = !occ_q[cnt_q] && (size_q[cnt_q] >= req_q);
  assign own = occ_q[cnt_q] && (owner_q[cnt_q] == id_q);

  always_comb begin
    case (op_q) inside
      fpa_pkg::OP_ASSIGN: match = fit;
      fpa_pkg::OP_FREE, fpa_pkg::OP_TRANSLATE,
      fpa_pkg::OP_READ, fpa_pkg::OP_WRITE: match = own;
      default: match = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      hit_q     <= 1'b0;
      hit_idx_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.scan) begin
      cnt_q <= cnt_q + 1'b1;
      if (match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cnt_q;
      end
    end
  end

  assign abs_sum = {1'b0, base_q[hit_idx_q]} + {1'b0, va_q};

  always_comb begin
    occ_d    = occ_q;
    owner_d  = owner_q;
    status_d = fpa_pkg::ST_OK;
    pidx_d   = '0;
    abs_d    = '0;
    case (op_q) inside
      fpa_pkg::OP_ASSIGN: begin
        if (hit_q) begin
          occ_d[hit_idx_q]   = 1'b1;
          owner_d[hit_idx_q] = id_q;
          pidx_d             = fpa_pkg::PART_INDEX_BITS'(hit_idx_q);
        end else begin
          status_d = fpa_pkg::ST_NOFIT;
        end
      end
      fpa_pkg::OP_FREE: begin
        if (hit_q) begin
          occ_d[hit_idx_q]   = 1'b0;
          owner_d[hit_idx_q] = '0;
          pidx_d             = fpa_pkg::PART_INDEX_BITS'(hit_idx_q);
        end else begin
          status_d = fpa_pkg::ST_NOTFOUND;
        end
      end
      fpa_pkg::OP_TRANSLATE, fpa_pkg::OP_READ, fpa_pkg::OP_WRITE: begin
        if (hit_q) begin
          pidx_d = fpa_pkg::PART_INDEX_BITS'(hit_idx_q);
          if (end_q > END_BITS'(size_q[hit_idx_q])) begin
            status_d = fpa_pkg::ST_BOUNDS;
          end else begin
            abs_d = abs_sum;
          end
        end else begin
          status_d = fpa_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        status_d = fpa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int p = 0; p < NSLOT; p++) begin
        owner_q[p] <= '0;
      end
    end else if (cmd_i.commit) begin
      occ_q   <= occ_d;
      owner_q <= owner_d;
    end
  end

  // Output register: holds one finished word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= status_d;
      pidx_q     <= pidx_d;
      abs_q      <= abs_d;
      all_free_q <= ~|occ_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.part_index  = pidx_q;
  assign rsp_o.abs_address = abs_q;
  assign rsp_o.all_free    = all_free_q;

  assign stat_o.match    = match;
  assign stat_o.last     = (cnt_q == IDX_BITS'(PARTS - 1));
  assign stat_o.out_free = !rsp_valid_q || rsp_o.ready;

endmodule

[rtl/core/fixed_partition_allocator_unit.sv]
// Fixed-partition allocator with first-fit placement.
// Requests arrive as words on req_i (valid/ready): an opcode (assign, free,
// translate, read check, write check), a program id, a size and a virtual
// address. Each request yields exactly one word on rsp_o: status, partition
// index, absolute address and a flag that tells whether all partitions are
// free afterwards. Partition bases and sizes are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must do so only while no request is
// in flight, as the block itself does not enforce it. A request is taken
// in the idle state, then the partitions are scanned one per cycle until
// the first match or the last partition, then the commit step updates the
// state and loads the output register, waiting while that register still
// holds an untaken word. A new request is taken only after the commit, in
// the idle state.
// Reset clears the configuration registers, all occupied flags and owner
// ids, and empties the output register. When the receiver stalls, the
// finished word waits in the output register; the next request may be
// accepted and scanned, and it waits at its commit step until that word is
// taken.
module fixed_partition_allocator_unit #(
  parameter int unsigned PARTS        = 4,
  parameter int unsigned ADDRESS_BITS = 20,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fpa_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [ADDRESS_BITS-1:0]            cfg_data_i,
  fpa_req_if.sink                            req_i,
  fpa_rsp_if.source                          rsp_o
);

  fpa_pkg::fpa_cmd_t  cmd;
  fpa_pkg::fpa_stat_t stat;
  logic               req_ready;

  assign req_i.ready = req_ready;

  fpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fpa_dp #(
    .PARTS        (PARTS),
    .ADDRESS_BITS (ADDRESS_BITS),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .req_opcode_i (req_i.opcode),
    .req_id_i     (req_i.prog_id),
    .req_size_i   (req_i.request_size),
    .req_va_i     (req_i.virt_addr),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .rsp_o        (rsp_o)
  );

endmodule
